// ===== rtl/core/sma_pkg.sv =====
// ----------------------------------------------------------------------------
// sma_pkg: shared types and constants of the moving average block
// Holds the field widths, the register map, the reset value of the window
// length and the state types of the front and back controllers.
// ----------------------------------------------------------------------------
`default_nettype none

package sma_pkg;

    // Field widths fixed by the interface.
    localparam int SAMPLE_W = 32;
    localparam int WLEN_W   = 9;

    // Default ring depth.
    localparam int WINDOW_MAX_DEF = 256;

    // Depth of the queue between the front and back parts.
    localparam int QUEUE_DEPTH = 2;

    // Configuration port.
    localparam int CFG_ADDR_W = 3;
    localparam int CFG_DATA_W = 32;

    // Register map (index = byte address / 4).
    localparam logic [0:0] REG_WINDOW_LENGTH = 1'b0;

    // Reset value of the window length register.
    localparam logic [WLEN_W-1:0] WLEN_RESET = 9'd20;

    // Front controller states.
    typedef enum logic [1:0] {
        F_IDLE,
        F_ADD,
        F_SUB,
        F_PUSH
    } t_front_state;

    // Back controller states.
    typedef enum logic [1:0] {
        B_IDLE,
        B_DIV,
        B_WRITE
    } t_back_state;

    // Queue status seen by both sides.
    typedef struct packed {
        logic full;
        logic empty;
    } t_queue_status;

endpackage

`default_nettype wire

// ===== rtl/core/sma_front.sv =====
// ----------------------------------------------------------------------------
// sma_front: sample intake, ring buffer and running sum
// Accepts one sample, swaps it into the ring, updates the running sum and
// the warm-up state, then pushes the sum and its valid flag to the queue.
// ----------------------------------------------------------------------------
`default_nettype none

module sma_front #(
    parameter int WINDOW_MAX = sma_pkg::WINDOW_MAX_DEF
) (
    input  wire                                                  i_clk,
    input  wire                                                  i_rst_n,
    input  wire                                                  i_clear,
    input  wire  [$clog2(WINDOW_MAX+1)-1:0]                      i_len,
    input  wire                                                  i_valid,
    output logic                                                 o_ready,
    input  wire  [sma_pkg::SAMPLE_W-1:0]                         i_sample,
    input  sma_pkg::t_queue_status                               i_qstat,
    output logic                                                 o_push,
    // Fields from the lowest bit up: running sum, result valid flag.
    output logic [sma_pkg::SAMPLE_W+$clog2(WINDOW_MAX):0]        o_entry
);
    import sma_pkg::*;

    localparam int SLOT_W = $clog2(WINDOW_MAX);
    localparam int LEN_W  = $clog2(WINDOW_MAX + 1);
    localparam int SUM_W  = SAMPLE_W + SLOT_W;

    t_front_state r_state, n_state;

    logic [SAMPLE_W-1:0] r_ring [WINDOW_MAX];
    logic [SAMPLE_W-1:0] r_old;
    logic [SAMPLE_W-1:0] r_sample;

    logic [SLOT_W-1:0] r_slot, n_slot;
    logic [LEN_W-1:0]  r_warm, n_warm;
    logic              r_full, n_full;
    logic [SUM_W-1:0]  r_sum,  n_sum;
    logic              r_sub,  n_sub;
    logic              r_pvalid, n_pvalid;

    logic             accept;
    logic [LEN_W-1:0] slot_inc;
    logic [LEN_W-1:0] warm_inc;

    assign accept   = i_valid && o_ready;
    assign slot_inc = LEN_W'(r_slot) + LEN_W'(1);
    assign warm_inc = r_warm + LEN_W'(1);

    // Ring buffer: read-first, so the oldest sample comes out as the new one goes in.
    // Entries are always written during warm-up before they are read back.
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_ring[r_slot] <= i_sample;
            r_old          <= r_ring[r_slot];
            r_sample       <= i_sample;
        end
    end

    // State register and control state.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= F_IDLE;
            r_slot   <= '0;
            r_warm   <= '0;
            r_full   <= 1'b0;
            r_sum    <= '0;
            r_sub    <= 1'b0;
            r_pvalid <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_slot   <= n_slot;
            r_warm   <= n_warm;
            r_full   <= n_full;
            r_sum    <= n_sum;
            r_sub    <= n_sub;
            r_pvalid <= n_pvalid;
        end
    end

    // Next state, sum update and classification of each beat.
    always_comb begin
        n_state  = r_state;
        n_slot   = r_slot;
        n_warm   = r_warm;
        n_full   = r_full;
        n_sum    = r_sum;
        n_sub    = r_sub;
        n_pvalid = r_pvalid;
        o_ready  = 1'b0;
        o_push   = 1'b0;

        unique case (r_state)
            F_IDLE: begin
                o_ready = 1'b1;
                if (i_valid) begin
                    n_slot = (slot_inc >= i_len) ? '0 : slot_inc[SLOT_W-1:0];
                    if (r_full) begin
                        n_sub    = 1'b1;
                        n_pvalid = 1'b1;
                    end else if (warm_inc < i_len) begin
                        n_warm   = warm_inc;
                        n_sub    = 1'b0;
                        n_pvalid = 1'b0;
                    end else begin
                        // Last warm-up sample completes the first window.
                        n_warm   = i_len;
                        n_full   = 1'b1;
                        n_sub    = 1'b0;
                        n_pvalid = 1'b1;
                    end
                    n_state = F_ADD;
                end
            end
            F_ADD: begin
                n_sum   = r_sum + {{(SUM_W-SAMPLE_W){r_sample[SAMPLE_W-1]}}, r_sample};
                n_state = F_SUB;
            end
            F_SUB: begin
                if (r_sub) begin
                    n_sum = r_sum - {{(SUM_W-SAMPLE_W){r_old[SAMPLE_W-1]}}, r_old};
                end
                n_state = F_PUSH;
            end
            F_PUSH: begin
                if (!i_qstat.full) begin
                    o_push  = 1'b1;
                    n_state = F_IDLE;
                end
            end
            default: begin
                n_state = F_IDLE;
            end
        endcase

        // A window length write restarts averaging with a fresh warm-up.
        if (i_clear) begin
            n_slot = '0;
            n_warm = '0;
            n_full = 1'b0;
            n_sum  = '0;
        end
    end

    assign o_entry = {r_pvalid, r_sum};

endmodule

`default_nettype wire

// ===== rtl/core/sma_queue.sv =====
// ----------------------------------------------------------------------------
// sma_queue: short queue between the front and back parts
// A small register queue that lets the front push a finished sum while the
// back is still dividing the previous one.
// ----------------------------------------------------------------------------
`default_nettype none

module sma_queue #(
    parameter int DATA_W = sma_pkg::SAMPLE_W + 9,
    parameter int DEPTH  = sma_pkg::QUEUE_DEPTH
) (
    input  wire                          i_clk,
    input  wire                          i_rst_n,
    input  wire                          i_push,
    input  wire  [DATA_W-1:0]            i_data,
    input  wire                          i_pop,
    output logic [DATA_W-1:0]            o_data,
    output sma_pkg::t_queue_status       o_stat
);
    import sma_pkg::*;

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    logic [DATA_W-1:0] r_mem [DEPTH];
    logic [PTR_W-1:0]  r_wr, r_rd;
    logic [CNT_W-1:0]  r_cnt;

    // Storage.
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_data;
        end
    end

    // Pointers and fill count.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) begin
                r_wr <= (r_wr == PTR_W'(DEPTH - 1)) ? '0 : r_wr + PTR_W'(1);
            end
            if (i_pop) begin
                r_rd <= (r_rd == PTR_W'(DEPTH - 1)) ? '0 : r_rd + PTR_W'(1);
            end
            if (i_push && !i_pop) begin
                r_cnt <= r_cnt + CNT_W'(1);
            end else if (i_pop && !i_push) begin
                r_cnt <= r_cnt - CNT_W'(1);
            end
        end
    end

    assign o_data       = r_mem[r_rd];
    assign o_stat.full  = (r_cnt == CNT_W'(DEPTH));
    assign o_stat.empty = (r_cnt == '0);

endmodule

`default_nettype wire

// ===== rtl/core/sma_back.sv =====
// ----------------------------------------------------------------------------
// sma_back: serial divider and output register
// Takes a sum from the queue, divides its magnitude by the window length one
// quotient bit per cycle, restores the sign and holds the result beat.
// ----------------------------------------------------------------------------
`default_nettype none

module sma_back #(
    parameter int WINDOW_MAX = sma_pkg::WINDOW_MAX_DEF
) (
    input  wire                                                  i_clk,
    input  wire                                                  i_rst_n,
    input  wire  [$clog2(WINDOW_MAX+1)-1:0]                      i_len,
    // Fields from the lowest bit up: running sum, result valid flag.
    input  wire  [sma_pkg::SAMPLE_W+$clog2(WINDOW_MAX):0]        i_entry,
    input  sma_pkg::t_queue_status                               i_qstat,
    output logic                                                 o_pop,
    output logic                                                 o_valid,
    input  wire                                                  i_ready,
    output logic [sma_pkg::SAMPLE_W-1:0]                         o_average,
    output logic                                                 o_valid_res
);
    import sma_pkg::*;

    localparam int LEN_W = $clog2(WINDOW_MAX + 1);
    localparam int SUM_W = SAMPLE_W + $clog2(WINDOW_MAX);
    localparam int CNT_W = $clog2(SUM_W + 1);

    t_back_state r_state, n_state;

    logic [SUM_W-1:0]    r_quo, n_quo;
    logic [LEN_W-1:0]    r_rem, n_rem;
    logic [CNT_W-1:0]    r_cnt, n_cnt;
    logic                r_neg, n_neg;
    logic                r_vres, n_vres;
    logic                r_ovalid, n_ovalid;
    logic [SAMPLE_W-1:0] r_avg, n_avg;
    logic                r_ores, n_ores;

    logic [SUM_W-1:0] ent_sum;
    logic [LEN_W:0]   rem_sh;
    logic [LEN_W:0]   rem_sub;
    logic             rem_ge;

    assign ent_sum = i_entry[SUM_W-1:0];

    // One restoring division step.
    assign rem_sh  = {r_rem, r_quo[SUM_W-1]};
    assign rem_ge  = (rem_sh >= {1'b0, i_len});
    assign rem_sub = rem_sh - {1'b0, i_len};

    // Registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= B_IDLE;
            r_ovalid <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_ovalid <= n_ovalid;
        end
        r_quo  <= n_quo;
        r_rem  <= n_rem;
        r_cnt  <= n_cnt;
        r_neg  <= n_neg;
        r_vres <= n_vres;
        r_avg  <= n_avg;
        r_ores <= n_ores;
    end

    // Next state, divider steps and output beat.
    always_comb begin
        n_state  = r_state;
        n_quo    = r_quo;
        n_rem    = r_rem;
        n_cnt    = r_cnt;
        n_neg    = r_neg;
        n_vres   = r_vres;
        n_avg    = r_avg;
        n_ores   = r_ores;
        n_ovalid = r_ovalid;
        o_pop    = 1'b0;

        // The held beat leaves when the consumer takes it.
        if (r_ovalid && i_ready) begin
            n_ovalid = 1'b0;
        end

        unique case (r_state)
            B_IDLE: begin
                if (!i_qstat.empty) begin
                    o_pop = 1'b1;
                    n_rem = '0;
                    n_cnt = CNT_W'(SUM_W);
                    if (i_entry[SUM_W]) begin
                        // Divide the magnitude; the sign comes back at the end.
                        n_neg   = ent_sum[SUM_W-1];
                        n_quo   = ent_sum[SUM_W-1] ? (~ent_sum + SUM_W'(1)) : ent_sum;
                        n_vres  = 1'b1;
                        n_state = B_DIV;
                    end else begin
                        // Warm-up result: zero, flagged not valid.
                        n_neg   = 1'b0;
                        n_quo   = '0;
                        n_vres  = 1'b0;
                        n_state = B_WRITE;
                    end
                end
            end
            B_DIV: begin
                n_rem = rem_ge ? rem_sub[LEN_W-1:0] : rem_sh[LEN_W-1:0];
                n_quo = {r_quo[SUM_W-2:0], rem_ge};
                n_cnt = r_cnt - CNT_W'(1);
                if (r_cnt == CNT_W'(1)) begin
                    n_state = B_WRITE;
                end
            end
            B_WRITE: begin
                if (!r_ovalid || i_ready) begin
                    n_avg    = r_neg ? (~r_quo[SAMPLE_W-1:0] + SAMPLE_W'(1))
                                     : r_quo[SAMPLE_W-1:0];
                    n_ores   = r_vres;
                    n_ovalid = 1'b1;
                    n_state  = B_IDLE;
                end
            end
            default: begin
                n_state = B_IDLE;
            end
        endcase
    end

    assign o_valid     = r_ovalid;
    assign o_average   = r_avg;
    assign o_valid_res = r_ores;

endmodule

`default_nettype wire

// ===== rtl/core/simple_moving_average.sv =====
// ----------------------------------------------------------------------------
// simple_moving_average: windowed mean of Q16.16 samples
// Averages the last window_length samples with a ring buffer and a running
// sum; results are flagged not valid until the first window is complete.
//
// Channel   Direction  Beat contents
// s_axis    in         tdata[31:0] sample
// m_axis    out        tdata[31:0] average, tuser[0] valid_res
// APB       in/out     window_length at byte address 0
//
// The front part steps through F_IDLE, F_ADD, F_SUB and F_PUSH per sample
// and takes no new one until back in F_IDLE; the back part runs the
// bit-serial divider for each valid beat and skips it for a warm-up beat,
// so the divider fixes the sustained rate. A two-entry queue and an output
// register let intake continue while a result waits on m_axis_tready.
// Reset is synchronous and needs no clearing pass: ring entries are always
// written during warm-up before they are read back. A window_length write
// restarts the warm-up.
// ----------------------------------------------------------------------------
`default_nettype none

module simple_moving_average #(
    parameter int WINDOW_MAX = sma_pkg::WINDOW_MAX_DEF
) (
    input  wire                               i_clk,
    input  wire                               i_rst_n,
    // Input stream.
    input  wire                               s_axis_tvalid,
    output logic                              s_axis_tready,
    input  wire  [sma_pkg::SAMPLE_W-1:0]      s_axis_tdata,   // [31:0] sample
    // Output stream.
    output logic                              m_axis_tvalid,
    input  wire                               m_axis_tready,
    output logic [sma_pkg::SAMPLE_W-1:0]      m_axis_tdata,   // [31:0] average
    output logic                              m_axis_tuser,   // [0] valid_res
    // Configuration port.
    input  wire                               psel,
    input  wire                               penable,
    input  wire                               pwrite,
    input  wire  [sma_pkg::CFG_ADDR_W-1:0]    paddr,
    input  wire  [sma_pkg::CFG_DATA_W-1:0]    pwdata,
    output logic [sma_pkg::CFG_DATA_W-1:0]    prdata,
    output logic                              pready
);
    import sma_pkg::*;

    localparam int LEN_W = $clog2(WINDOW_MAX + 1);
    localparam int SUM_W = SAMPLE_W + $clog2(WINDOW_MAX);
    localparam int CMP_W = (LEN_W > WLEN_W) ? LEN_W : WLEN_W;

    logic [WLEN_W-1:0] r_wlen;
    logic              cfg_wr;
    logic              cfg_hit;
    logic [CMP_W-1:0]  wlen_ext;
    logic [LEN_W-1:0]  eff_len;

    logic             push;
    logic             pop;
    logic [SUM_W:0]   push_entry;
    logic [SUM_W:0]   pop_entry;
    t_queue_status    qstat;

    // Register write decode.
    assign pready  = 1'b1;
    assign cfg_hit = (paddr[CFG_ADDR_W-1:2] == REG_WINDOW_LENGTH);
    assign cfg_wr  = psel && penable && pwrite && pready && cfg_hit;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wlen <= WLEN_RESET;
        end else if (cfg_wr) begin
            r_wlen <= pwdata[WLEN_W-1:0];
        end
    end

    assign prdata = cfg_hit ? CFG_DATA_W'(r_wlen) : '0;

    // Effective length: zero counts as one, values above the depth saturate.
    assign wlen_ext = CMP_W'(r_wlen);

    always_comb begin
        if (r_wlen == '0) begin
            eff_len = LEN_W'(1);
        end else if (wlen_ext > CMP_W'(WINDOW_MAX)) begin
            eff_len = LEN_W'(WINDOW_MAX);
        end else begin
            eff_len = wlen_ext[LEN_W-1:0];
        end
    end

    // Front part: intake, ring and running sum.
    sma_front #(
        .WINDOW_MAX (WINDOW_MAX)
    ) u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_clear  (cfg_wr),
        .i_len    (eff_len),
        .i_valid  (s_axis_tvalid),
        .o_ready  (s_axis_tready),
        .i_sample (s_axis_tdata),
        .i_qstat  (qstat),
        .o_push   (push),
        .o_entry  (push_entry)
    );

    // Queue between the two parts.
    sma_queue #(
        .DATA_W (SUM_W + 1),
        .DEPTH  (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_data  (push_entry),
        .i_pop   (pop),
        .o_data  (pop_entry),
        .o_stat  (qstat)
    );

    // Back part: division and result register.
    sma_back #(
        .WINDOW_MAX (WINDOW_MAX)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_len       (eff_len),
        .i_entry     (pop_entry),
        .i_qstat     (qstat),
        .o_pop       (pop),
        .o_valid     (m_axis_tvalid),
        .i_ready     (m_axis_tready),
        .o_average   (m_axis_tdata),
        .o_valid_res (m_axis_tuser)
    );

endmodule

`default_nettype wire

// ===== dv/tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb: self-checking bench for simple_moving_average
// Streams signed Q16.16 samples into the block under several window lengths
// and checks every output beat against an in-bench model of the ring buffer
// and running sum. Both stream sides idle at random, and the output side
// holds off once for a long stretch so that the block backs up its input.
// ----------------------------------------------------------------------------

module tb;

    import sma_pkg::*;

    localparam int          WINDOW_MAX  = WINDOW_MAX_DEF;
    localparam int unsigned CYCLE_LIMIT = 1000000;
    localparam int unsigned HOLD_AT     = 100;
    localparam int unsigned HOLD_CYCLES = 600;
    localparam int unsigned TAIL_CYCLES = 60;
    localparam int unsigned IDX_UNUSED  = 1;

    // Byte addresses of the register map.
    localparam logic [CFG_ADDR_W-1:0] ADDR_WLEN   = CFG_ADDR_W'(int'(REG_WINDOW_LENGTH) * 4);
    localparam logic [CFG_ADDR_W-1:0] ADDR_UNUSED = CFG_ADDR_W'(IDX_UNUSED * 4);

    // Sample values with a special meaning.
    localparam logic [SAMPLE_W-1:0] SMP_MAX     = 32'h7FFF_FFFF;
    localparam logic [SAMPLE_W-1:0] SMP_MIN     = 32'h8000_0000;
    localparam logic [SAMPLE_W-1:0] SMP_ONE     = 32'h0001_0000;
    localparam logic [SAMPLE_W-1:0] SMP_NEG_ONE = 32'hFFFF_0000;

    typedef struct packed {
        logic [SAMPLE_W-1:0] average;
        logic                valid_res;
    } t_avg_beat;

    logic                  i_clk;
    logic                  i_rst_n       = 1'b0;
    logic                  s_axis_tvalid = 1'b0;
    logic                  s_axis_tready;
    logic [SAMPLE_W-1:0]   s_axis_tdata  = '0;    // [31:0] sample
    logic                  m_axis_tvalid;
    logic                  m_axis_tready = 1'b0;
    logic [SAMPLE_W-1:0]   m_axis_tdata;          // [31:0] average
    logic                  m_axis_tuser;          // [0] valid_res
    logic                  psel          = 1'b0;
    logic                  penable       = 1'b0;
    logic                  pwrite        = 1'b0;
    logic [CFG_ADDR_W-1:0] paddr         = '0;
    logic [CFG_DATA_W-1:0] pwdata        = '0;
    logic [CFG_DATA_W-1:0] prdata;
    logic                  pready;

    simple_moving_average #(
        .WINDOW_MAX(WINDOW_MAX)
    ) uut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready)
    );

    // Model state of the averaging window.
    logic [SAMPLE_W-1:0] hist_mem [WINDOW_MAX];
    logic [WLEN_W-1:0]   win_len_reg;
    int unsigned         hist_ptr;
    int unsigned         fill_count;
    longint              acc_sum;
    bit                  primed;

    logic [SAMPLE_W-1:0] sample_q[$];
    t_avg_beat           avg_expect_q[$];
    t_avg_beat           oldest_avg;

    int unsigned err_count    = 0;
    int unsigned results_seen = 0;
    int unsigned cycle_count  = 0;
    int unsigned gap_left     = 0;
    int unsigned stall_left   = 0;
    int unsigned hold_left    = 0;
    bit          hold_done    = 1'b0;
    bit          no_gap_run   = 1'b0;

    // Clock generation.
    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    task automatic report_mismatch(input string what);
        err_count++;
        $display("mismatch at result %0d: %s", results_seen, what);
    endtask

    // Empties the window, as after reset or any window_length write.
    function automatic void clear_history();
        foreach (hist_mem[i]) hist_mem[i] = '0;
        hist_ptr   = 0;
        fill_count = 0;
        acc_sum    = 0;
        primed     = 1'b0;
    endfunction

    // Register write as seen by the model; unknown indexes leave all unchanged.
    function automatic void apply_register_write(input logic [CFG_ADDR_W-1:0] addr,
                                                 input logic [CFG_DATA_W-1:0] data);
        if (int'(addr >> 2) == int'(REG_WINDOW_LENGTH)) begin
            win_len_reg = data[WLEN_W-1:0];
            clear_history();
        end
    endfunction

    // Advances the window by one sample and queues the expected output beat.
    function automatic void advance_average(input logic [SAMPLE_W-1:0] smp);
        int unsigned n;
        int unsigned ptr;
        longint      oldest;
        t_avg_beat   beat;
        n = (win_len_reg == 0) ? 1 : int'(win_len_reg);
        if (n > WINDOW_MAX) n = WINDOW_MAX;
        ptr = hist_ptr;
        if (ptr >= n) ptr = 0;
        oldest = longint'(signed'(hist_mem[ptr]));
        hist_mem[ptr] = smp;
        ptr++;
        if (ptr >= n) ptr = 0;
        hist_ptr = ptr;
        acc_sum += longint'(signed'(smp));
        if (!primed) begin
            if (fill_count + 1 < n) begin
                // Still warming up: the beat carries zero and is not valid.
                fill_count++;
                beat.average   = '0;
                beat.valid_res = 1'b0;
                avg_expect_q.push_back(beat);
                return;
            end
            fill_count = n;
            primed     = 1'b1;
        end else begin
            acc_sum -= oldest;
        end
        // Signed division truncates toward zero.
        beat.average   = SAMPLE_W'(acc_sum / longint'(n));
        beat.valid_res = 1'b1;
        avg_expect_q.push_back(beat);
    endfunction

    // Idle length: mostly none or short, now and then long.
    function automatic int unsigned pick_gap();
        int unsigned r;
        if (no_gap_run) return 0;
        r = $urandom_range(0, 99);
        if (r < 55) return 0;
        if (r < 90) return $urandom_range(1, 3);
        if (r < 97) return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    // Random sample biased toward full-scale and small values.
    function automatic logic [SAMPLE_W-1:0] pick_sample();
        case ($urandom_range(0, 9))
            0: return SMP_MAX;
            1: return SMP_MIN;
            2: return SAMPLE_W'(int'($urandom_range(0, 262144)) - 131072);
            default: return SAMPLE_W'($urandom);
        endcase
    endfunction

    // Input driver: offers queued samples and updates the model on each beat.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            s_axis_tvalid <= 1'b0;
            gap_left = 0;
        end else begin
            if (s_axis_tvalid && s_axis_tready) advance_average(s_axis_tdata);
            if (!s_axis_tvalid || s_axis_tready) begin
                if (gap_left > 0) begin
                    gap_left--;
                    s_axis_tvalid <= 1'b0;
                end else if (sample_q.size() > 0) begin
                    s_axis_tdata  <= sample_q.pop_front();
                    s_axis_tvalid <= 1'b1;
                    gap_left = pick_gap();
                end else begin
                    s_axis_tvalid <= 1'b0;
                end
            end
        end
    end

    // Output ready: random stalls, plus one long hold-off to back up the block.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            m_axis_tready <= 1'b0;
            stall_left = 0;
        end else if (hold_left > 0) begin
            hold_left--;
            m_axis_tready <= 1'b0;
        end else if (!hold_done && results_seen >= HOLD_AT) begin
            hold_done = 1'b1;
            hold_left = HOLD_CYCLES;
            m_axis_tready <= 1'b0;
        end else if (stall_left > 0) begin
            stall_left--;
            m_axis_tready <= 1'b0;
        end else begin
            m_axis_tready <= 1'b1;
            stall_left = pick_gap();
        end
    end

    // Output monitor: each beat is compared with the oldest expectation.
    always @(posedge i_clk) begin
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            results_seen++;
            if (avg_expect_q.size() == 0) begin
                report_mismatch($sformatf("unexpected beat, average %h valid_res %b",
                                          m_axis_tdata, m_axis_tuser));
            end else begin
                oldest_avg = avg_expect_q.pop_front();
                if (m_axis_tdata !== oldest_avg.average)
                    report_mismatch($sformatf("average %h, expected %h",
                                              m_axis_tdata, oldest_avg.average));
                if (m_axis_tuser !== oldest_avg.valid_res)
                    report_mismatch($sformatf("valid_res %b, expected %b",
                                              m_axis_tuser, oldest_avg.valid_res));
            end
        end
    end

    // Watchdog on the total run length.
    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("FAIL");
            $finish;
        end
    end

    // Register write with a setup and an access phase; the model follows at the write edge.
    task automatic apb_write(input logic [CFG_ADDR_W-1:0] addr,
                             input logic [CFG_DATA_W-1:0] data);
        @(posedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= addr;
        pwdata  <= data;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        apply_register_write(addr, data);
    endtask

    // Waits until every sample is sent and every result has come back.
    task automatic wait_drained();
        do @(negedge i_clk);
        while (sample_q.size() != 0 || s_axis_tvalid || avg_expect_q.size() != 0);
    endtask

    // One setting: write a register while idle, then stream random samples.
    task automatic run_phase(input logic [CFG_ADDR_W-1:0] addr, input logic [WLEN_W-1:0] wval,
                             input int unsigned count, input bit calm);
        wait_drained();
        repeat (4) @(posedge i_clk);
        // Upper data bits are random; only the low bits belong to the register.
        apb_write(addr, {(CFG_DATA_W - WLEN_W)'($urandom_range(0,
                         (1 << (CFG_DATA_W - WLEN_W)) - 1)), wval});
        no_gap_run = calm;
        repeat (count) sample_q.push_back(pick_sample());
    endtask

    // Stimulus sequence and final verdict.
    initial begin
        win_len_reg = WLEN_RESET;
        clear_history();
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed: extremes through warm-up at the reset length, then the first
        // replacements of old samples by full-scale negative ones.
        sample_q.push_back(SMP_MAX);
        sample_q.push_back(SMP_MIN);
        sample_q.push_back('0);
        sample_q.push_back('1);
        sample_q.push_back(SAMPLE_W'(1));
        sample_q.push_back(SMP_ONE);
        sample_q.push_back(SMP_NEG_ONE);
        repeat (13) sample_q.push_back(SMP_MAX);
        repeat (2) sample_q.push_back(SMP_MIN);

        // Zero length acts as one, then the smallest real windows.
        run_phase(ADDR_WLEN, 9'd0, 20, 1'b0);
        run_phase(ADDR_WLEN, 9'd1, 20, 1'b1);
        run_phase(ADDR_WLEN, 9'd2, 20, 1'b0);
        // Full depth; the long output hold-off falls in this phase.
        run_phase(ADDR_WLEN, 9'(WINDOW_MAX), 262, 1'b0);
        // A write to an unknown index must leave the window sliding on.
        run_phase(ADDR_UNUSED, 9'($urandom_range(0, 511)), 20, 1'b1);
        // Lengths above the depth saturate to the depth.
        run_phase(ADDR_WLEN, 9'd511, 262, 1'b0);
        // Short random windows.
        repeat (2) run_phase(ADDR_WLEN, 9'($urandom_range(3, 12)), 30, 1'b0);

        wait_drained();
        repeat (TAIL_CYCLES) @(posedge i_clk);
        if (err_count == 0 && avg_expect_q.size() == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

endmodule

// ===== simple_moving_average.f =====
rtl/core/sma_pkg.sv
rtl/core/sma_front.sv
rtl/core/sma_queue.sv
rtl/core/sma_back.sv
rtl/core/simple_moving_average.sv
dv/tb.sv
